/* rtl/sdbm_pkg.sv */
// Shared types and constants for the sparse dot-product best-match core.
package sdbm_pkg;

    localparam int QUERY_DEPTH_DEF = 32;
    localparam int INDEX_BITS_DEF  = 16;

    localparam int INDEX_W = 16;
    localparam int VALUE_W = 16;
    localparam int SCORE_W = 48;

    // query entries summed per group in the group-sum stage
    localparam int GROUP_SIZE = 8;

    // -1.0 in Q.16
    localparam logic signed [SCORE_W-1:0] BEST_INIT = -48'sd65536;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BANK  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_START = 2'd3
    } req_t;

    // store commands from the input stage
    typedef struct packed {
        logic load;
        logic clear;
    } qctl_t;

endpackage

/* rtl/sdbm_qstore.sv */
// Query entry store with parallel key match and grouped weight sums.
module sdbm_qstore #(
    parameter int QUERY_DEPTH = sdbm_pkg::QUERY_DEPTH_DEF,
    parameter int INDEX_BITS  = sdbm_pkg::INDEX_BITS_DEF,
    localparam int KEY_W   = (INDEX_BITS < sdbm_pkg::INDEX_W) ? INDEX_BITS : sdbm_pkg::INDEX_W,
    localparam int NGROUPS = (QUERY_DEPTH + sdbm_pkg::GROUP_SIZE - 1) / sdbm_pkg::GROUP_SIZE,
    localparam int GSUM_W  = sdbm_pkg::VALUE_W + $clog2(sdbm_pkg::GROUP_SIZE)
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  sdbm_pkg::qctl_t                          ctl,
    input  logic [KEY_W-1:0]                         key,
    input  logic signed [sdbm_pkg::VALUE_W-1:0]      weight,
    output logic                                     full,
    output logic [NGROUPS-1:0][GSUM_W-1:0]           grp_sum
);

    localparam int FILL_W  = $clog2(QUERY_DEPTH + 1);
    localparam int ADDR_W  = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
    localparam int PAD_N   = NGROUPS * sdbm_pkg::GROUP_SIZE;

    logic [KEY_W-1:0]                    key_mem_reg    [QUERY_DEPTH];
    logic signed [sdbm_pkg::VALUE_W-1:0] weight_mem_reg [QUERY_DEPTH];
    logic [FILL_W-1:0]                   fill_reg;
    logic [FILL_W-1:0]                   fill_next;
    logic signed [sdbm_pkg::VALUE_W-1:0] masked_w [PAD_N];

    assign full = (fill_reg == FILL_W'(QUERY_DEPTH));

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            fill_next = '0;
        end
        else if (ctl.load && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && !full)
        begin
            key_mem_reg[fill_reg[ADDR_W-1:0]]    <= key;
            weight_mem_reg[fill_reg[ADDR_W-1:0]] <= weight;
        end
    end

    // one comparator per entry; entries at or above the fill count do not match
    for (genvar i = 0; i < PAD_N; i++)
    begin : g_match
        if (i < QUERY_DEPTH)
        begin : g_live
            assign masked_w[i] = ((FILL_W'(i) < fill_reg) && (key_mem_reg[i] == key))
                               ? weight_mem_reg[i] : '0;
        end
        else
        begin : g_pad
            assign masked_w[i] = '0;
        end
    end

    always_comb
    begin
        logic signed [GSUM_W-1:0] acc;
        for (int g = 0; g < NGROUPS; g++)
        begin
            acc = '0;
            for (int k = 0; k < sdbm_pkg::GROUP_SIZE; k++)
            begin
                acc = acc + GSUM_W'(masked_w[g * sdbm_pkg::GROUP_SIZE + k]);
            end
            grp_sum[g] = acc;
        end
    end

endmodule

/* rtl/sparse_dot_best_match_core.sv */
// Top level of the sparse dot-product best-match search core.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_ready  req_type, entry_index, entry_value, last_vector
//   out       source     out_valid/out_ready  best_index, peak_score, query_overflowed
//
// One transaction enters per cycle while the input side is not stalled. A closing
// transaction, once accepted, fills the input register, then moves through the
// group-sum, weight-sum and product registers in turn, and the accumulate/compare
// logic behind the product register loads the result register.
// Reset clears the query fill count, running score, vector count, best match
// (index 0, score -1.0) and the overflow flag; query store contents stay undefined.
// The input side stalls only while the last stage holds a final close and the
// result register still holds an untaken result; other transactions keep flowing.
module sparse_dot_best_match_core #(
    parameter int QUERY_DEPTH = sdbm_pkg::QUERY_DEPTH_DEF,
    parameter int INDEX_BITS  = sdbm_pkg::INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [sdbm_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [sdbm_pkg::VALUE_W-1:0] entry_value,
    input  logic                                last_vector,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sdbm_pkg::INDEX_W-1:0]        best_index,
    output logic signed [sdbm_pkg::SCORE_W-1:0] peak_score,
    output logic                                query_overflowed
);

    localparam int KEY_W   = (INDEX_BITS < sdbm_pkg::INDEX_W) ? INDEX_BITS : sdbm_pkg::INDEX_W;
    localparam int NGROUPS = (QUERY_DEPTH + sdbm_pkg::GROUP_SIZE - 1) / sdbm_pkg::GROUP_SIZE;
    localparam int GSUM_W  = sdbm_pkg::VALUE_W + $clog2(sdbm_pkg::GROUP_SIZE);
    localparam int WSUM_W  = sdbm_pkg::VALUE_W + $clog2(NGROUPS * sdbm_pkg::GROUP_SIZE);
    localparam int PROD_W  = WSUM_W + sdbm_pkg::VALUE_W;
    localparam int ACC_W   = sdbm_pkg::SCORE_W + 1;

    localparam logic signed [sdbm_pkg::SCORE_W-1:0] SCORE_MAX =
        {1'b0, {(sdbm_pkg::SCORE_W-1){1'b1}}};
    localparam logic signed [sdbm_pkg::SCORE_W-1:0] SCORE_MIN =
        {1'b1, {(sdbm_pkg::SCORE_W-1){1'b0}}};

    // ---------------------------------------------------------------
    // Pipeline control: advance everything unless a final close in the
    // last stage cannot hand its result to the result register.
    // ---------------------------------------------------------------
    logic advance;
    logic stall;
    logic emit;

    // stage A: input register
    logic                                a_valid_reg;
    sdbm_pkg::req_t                      a_req_reg;
    logic [KEY_W-1:0]                    a_key_reg;
    logic signed [sdbm_pkg::VALUE_W-1:0] a_val_reg;
    logic                                a_last_reg;

    // stage B: group sums
    logic                                b_valid_reg;
    sdbm_pkg::req_t                      b_req_reg;
    logic signed [sdbm_pkg::VALUE_W-1:0] b_val_reg;
    logic                                b_last_reg;
    logic                                b_drop_reg;
    logic [NGROUPS-1:0][GSUM_W-1:0]      b_grp_reg;

    // stage C: total matched weight
    logic                                c_valid_reg;
    sdbm_pkg::req_t                      c_req_reg;
    logic signed [sdbm_pkg::VALUE_W-1:0] c_val_reg;
    logic                                c_last_reg;
    logic                                c_drop_reg;
    logic signed [WSUM_W-1:0]            c_wsum_reg;

    // stage D: product, applied to the search state
    logic                                d_valid_reg;
    sdbm_pkg::req_t                      d_req_reg;
    logic                                d_last_reg;
    logic                                d_drop_reg;
    logic signed [PROD_W-1:0]            d_prod_reg;

    // search state
    logic signed [sdbm_pkg::SCORE_W-1:0] score_reg;
    logic signed [sdbm_pkg::SCORE_W-1:0] score_next;
    logic [sdbm_pkg::INDEX_W-1:0]        count_reg;
    logic [sdbm_pkg::INDEX_W-1:0]        count_next;
    logic [sdbm_pkg::INDEX_W-1:0]        best_idx_reg;
    logic [sdbm_pkg::INDEX_W-1:0]        best_idx_next;
    logic signed [sdbm_pkg::SCORE_W-1:0] best_val_reg;
    logic signed [sdbm_pkg::SCORE_W-1:0] best_val_next;
    logic                                ovf_reg;
    logic                                ovf_next;

    // result register
    logic                                out_valid_reg;
    logic [sdbm_pkg::INDEX_W-1:0]        best_index_reg;
    logic signed [sdbm_pkg::SCORE_W-1:0] peak_score_reg;
    logic                                ovf_out_reg;

    sdbm_pkg::qctl_t                     qctl;
    logic                                q_full;
    logic [NGROUPS-1:0][GSUM_W-1:0]      q_grp_sum;
    logic signed [WSUM_W-1:0]            b_wsum;
    logic signed [PROD_W-1:0]            c_prod;
    logic signed [ACC_W-1:0]             acc_sum;
    logic signed [sdbm_pkg::SCORE_W-1:0] acc_sat;

    assign stall    = d_valid_reg && (d_req_reg == sdbm_pkg::REQ_CLOSE) && d_last_reg
                   && out_valid_reg && !out_ready;
    assign advance  = !stall;
    assign in_ready = advance;
    assign emit     = advance && d_valid_reg && (d_req_reg == sdbm_pkg::REQ_CLOSE) && d_last_reg;

    // ---------------------------------------------------------------
    // Stage A: hold the accepted transaction; the query store sees it
    // and commits loads and clears as it moves on.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_req_reg  <= sdbm_pkg::req_t'(req_type);
            a_key_reg  <= entry_index[KEY_W-1:0];
            a_val_reg  <= entry_value;
            a_last_reg <= last_vector;
        end
    end

    assign qctl.load  = advance && a_valid_reg && (a_req_reg == sdbm_pkg::REQ_LOAD);
    assign qctl.clear = advance && a_valid_reg && (a_req_reg == sdbm_pkg::REQ_START);

    sdbm_qstore #(
        .QUERY_DEPTH (QUERY_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) u_qstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (qctl),
        .key     (a_key_reg),
        .weight  (a_val_reg),
        .full    (q_full),
        .grp_sum (q_grp_sum)
    );

    // ---------------------------------------------------------------
    // Stage B: register group sums; a load that met a full store is
    // marked dropped so the flag lands in order with later results.
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_req_reg  <= a_req_reg;
            b_val_reg  <= a_val_reg;
            b_last_reg <= a_last_reg;
            b_drop_reg <= q_full;
            b_grp_reg  <= q_grp_sum;
        end
    end

    always_comb
    begin
        b_wsum = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            b_wsum = b_wsum + WSUM_W'($signed(b_grp_reg[g]));
        end
    end

    // Stage C: total matched weight times bank value
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_req_reg  <= b_req_reg;
            c_val_reg  <= b_val_reg;
            c_last_reg <= b_last_reg;
            c_drop_reg <= b_drop_reg;
            c_wsum_reg <= b_wsum;
        end
    end

    assign c_prod = PROD_W'(c_wsum_reg) * PROD_W'(c_val_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_req_reg  <= c_req_reg;
            d_last_reg <= c_last_reg;
            d_drop_reg <= c_drop_reg;
            d_prod_reg <= c_prod;
        end
    end

    // ---------------------------------------------------------------
    // Stage D: saturating accumulate, close-vector compare, restart.
    // ---------------------------------------------------------------
    assign acc_sum = ACC_W'(score_reg) + ACC_W'(d_prod_reg);

    always_comb
    begin
        if (acc_sum[ACC_W-1] != acc_sum[ACC_W-2])
        begin
            acc_sat = acc_sum[ACC_W-1] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            acc_sat = acc_sum[sdbm_pkg::SCORE_W-1:0];
        end
    end

    always_comb
    begin
        score_next    = score_reg;
        count_next    = count_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        ovf_next      = ovf_reg;
        if (d_valid_reg)
        begin
            case (d_req_reg)
                sdbm_pkg::REQ_START:
                begin
                    score_next    = '0;
                    count_next    = '0;
                    best_idx_next = '0;
                    best_val_next = sdbm_pkg::BEST_INIT;
                    ovf_next      = 1'b0;
                end
                sdbm_pkg::REQ_LOAD:
                begin
                    ovf_next = ovf_reg || d_drop_reg;
                end
                sdbm_pkg::REQ_BANK:
                begin
                    score_next = acc_sat;
                end
                sdbm_pkg::REQ_CLOSE:
                begin
                    // keep the first vector on a tie
                    if (score_reg > best_val_reg)
                    begin
                        best_val_next = score_reg;
                        best_idx_next = count_reg;
                    end
                    count_next = count_reg + 1'b1;
                    score_next = '0;
                end
                default:
                begin
                    score_next = score_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg    <= '0;
            count_reg    <= '0;
            best_idx_reg <= '0;
            best_val_reg <= sdbm_pkg::BEST_INIT;
            ovf_reg      <= 1'b0;
        end
        else if (advance)
        begin
            score_reg    <= score_next;
            count_reg    <= count_next;
            best_idx_reg <= best_idx_next;
            best_val_reg <= best_val_next;
            ovf_reg      <= ovf_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register: load on a final close, drop once taken.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            best_index_reg <= best_idx_next;
            peak_score_reg <= best_val_next;
            ovf_out_reg    <= ovf_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign best_index       = best_index_reg;
    assign peak_score       = peak_score_reg;
    assign query_overflowed = ovf_out_reg;

`ifndef ASSERT_OFF
    a_stall_only_on_blocked_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    a_best_not_below_init: assert property (@(posedge clk) disable iff (!rst_n)
        best_val_reg >= sdbm_pkg::BEST_INIT)
        else $error("best score fell below -1.0");

    a_result_from_final_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past(d_valid_reg && d_last_reg && (d_req_reg == sdbm_pkg::REQ_CLOSE)))
        else $error("result raised without a final close");
`endif

endmodule
